/* rtl/rsa_mexp_pkg.sv */
// ----------------------------------------------------------------------------
// RSA modular exponentiation - shared definitions
// Word width, register indexes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package rsa_mexp_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam int IDX_W     = 2;

  typedef logic [WORD_BITS-1:0] word_t;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_PUB_EXP  = 2'd1,
    REG_PRIV_EXP = 2'd2
  } reg_idx_t;

  localparam word_t MODULUS_RST  = WORD_BITS'(391);
  localparam word_t PUB_EXP_RST  = WORD_BITS'(3);
  localparam word_t PRIV_EXP_RST = WORD_BITS'(235);

  // operand selection for a new multiply
  typedef enum logic [0:0] {
    SEL_ACC = 1'b0,   // acc * sq
    SEL_SQ  = 1'b1    // sq * sq
  } mul_sel_t;

  typedef struct packed {
    logic     load;      // capture message / exponent, start reduction of message
    logic     mul_start; // clear partial product, load operands
    mul_sel_t mul_sel;
    logic     mul_step;  // one multiplier bit
    logic     wb_acc;    // product -> acc
    logic     wb_sq;     // product -> sq (also ends message reduction)
    logic     exp_shift; // next exponent bit
    logic     res_load;  // result -> output register
  } cmd_t;

  typedef struct packed {
    logic exp_zero;      // no set exponent bits left
    logic exp_lsb;       // current exponent bit
  } sts_t;

endpackage

/* rtl/rsa_mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// RSA modular exponentiation - controller
// Sequences message reduction, square-and-multiply and result hand-off.
// ----------------------------------------------------------------------------
module rsa_mexp_ctrl import rsa_mexp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_accept,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RED  = 6'b000010,
    ST_TEST = 6'b000100,
    ST_MACC = 6'b001000,
    ST_MSQ  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last;

  assign last      = (cnt_r == '0);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        cmd.mul_step = 1'b1;
        if (last) begin
          cmd.wb_sq = 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.exp_zero) begin
          state_nxt = ST_FIN;
        end else if (sts.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_ACC;
          state_nxt     = ST_MACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_SQ;
          state_nxt     = ST_MSQ;
        end
      end
      ST_MACC: begin
        cmd.mul_step = 1'b1;
        if (last) begin
          cmd.wb_acc    = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_SQ;
          state_nxt     = ST_MSQ;
        end
      end
      ST_MSQ: begin
        cmd.mul_step = 1'b1;
        if (last) begin
          cmd.wb_sq     = 1'b1;
          cmd.exp_shift = 1'b1;
          state_nxt     = ST_TEST;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load || cmd.mul_start) begin
      cnt_nxt = CNT_W'(WORD_BITS - 1);
    end else if (cmd.mul_step) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/rsa_mexp_dp.sv */
// ----------------------------------------------------------------------------
// RSA modular exponentiation - datapath
// Key registers, bit-serial interleaved modular multiplier, acc/sq/exp regs.
// ----------------------------------------------------------------------------
module rsa_mexp_dp import rsa_mexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_idx,
  input  word_t                cfg_wdata,
  input  logic                 op,
  input  word_t                message,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output word_t                result
);

  localparam int TW = WORD_BITS + 2;

  word_t modulus_r, pub_exp_r, priv_exp_r;
  word_t a_r, b_r, p_r, acc_r, sq_r, exp_r, res_r;
  logic  zexp_r;

  word_t         one_m, p_step;
  logic [TW-1:0] t, m1, m2;
  logic [TW:0]   d1, d2;

  // 1 mod m (m == 0 wraps, so 1 stays)
  assign one_m = (modulus_r == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

  // one interleaved step: p = (2p + bit*a) mod m, with p, a < m, so t < 3m
  always_comb begin
    t  = {1'b0, p_r, 1'b0} + {2'b00, (b_r[WORD_BITS-1] ? a_r : word_t'(0))};
    m1 = {2'b00, modulus_r};
    m2 = {1'b0, modulus_r, 1'b0};
    d1 = {1'b0, t} - {1'b0, m1};
    d2 = {1'b0, t} - {1'b0, m2};
    if (modulus_r == '0) begin
      p_step = t[WORD_BITS-1:0];
    end else if (!d2[TW]) begin
      p_step = d2[WORD_BITS-1:0];
    end else if (!d1[TW]) begin
      p_step = d1[WORD_BITS-1:0];
    end else begin
      p_step = t[WORD_BITS-1:0];
    end
  end

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MODULUS_RST;
      pub_exp_r  <= PUB_EXP_RST;
      priv_exp_r <= PRIV_EXP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODULUS:  modulus_r  <= cfg_wdata;
        REG_PUB_EXP:  pub_exp_r  <= cfg_wdata;
        REG_PRIV_EXP: priv_exp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // working registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= one_m;      // message * (1 mod m) reduces the message
      b_r    <= message;
      p_r    <= '0;
      exp_r  <= op ? priv_exp_r : pub_exp_r;
      zexp_r <= op ? (priv_exp_r == '0) : (pub_exp_r == '0);
    end else if (cmd.mul_start) begin
      a_r <= sq_r;
      b_r <= (cmd.mul_sel == SEL_ACC) ? acc_r : sq_r;
      p_r <= '0;
    end else if (cmd.mul_step) begin
      b_r <= {b_r[WORD_BITS-2:0], 1'b0};
      p_r <= p_step;
    end
    if (cmd.wb_sq) begin
      sq_r <= p_step;
    end
    if (cmd.load) begin
      acc_r <= one_m;
    end else if (cmd.wb_acc) begin
      acc_r <= p_step;
    end
    if (cmd.exp_shift) begin
      exp_r <= {1'b0, exp_r[WORD_BITS-1:1]};
    end
    if (cmd.res_load) begin
      res_r <= zexp_r ? WORD_BITS'(1) : acc_r;
    end
  end

  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_lsb  = exp_r[0];
  assign result       = res_r;

endmodule

/* rtl/rsa_modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// RSA modular exponentiation - top level
// message ^ e (encrypt) or message ^ d (decrypt) mod n, square-and-multiply.
// ----------------------------------------------------------------------------
//  channel  direction  beat contents
//  in_      slave      tdata = message[31:0], tuser = op (0 encrypt, 1 decrypt)
//  out_     master     tdata = result[31:0]
//  cfg_     slave      index 0 modulus, 1 public exp, 2 private exp; data 32b
//
//  Sequence: message reduction, then per exponent bit up to the top set
//  bit: a test, a multiply if the bit is set, then a square; then the
//  hand-off. The multiplier works one bit a cycle.
//  Zero exponent: result 1.
//  Reset: rst_n synchronous, active low; key registers return to 391 / 3 / 235.
//  Stalls: one input beat in work at a time; a finished result waits in the
//  output register and the next beat is taken meanwhile. cfg_ready stays high;
//  write the keys only while idle.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation import rsa_mexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [WORD_BITS-1:0] in_tdata,   // [31:0] message
  input  logic                 in_tuser,   // [0] op
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_BITS-1:0] out_tdata,  // [31:0] result
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic in_accept;

  assign in_accept = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  rsa_mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsa_mexp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .op        (in_tuser),
    .message   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .result    (out_tdata)
  );

endmodule

/* rtl/rsa_mexp_chk.sv */
// ----------------------------------------------------------------------------
// RSA modular exponentiation - port checker
// Watches the top level's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module rsa_mexp_chk import rsa_mexp_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [WORD_BITS-1:0] out_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed under stall");

  // one beat in work: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // no result can come straight out of an accept
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared one cycle after accept");

  // the block frees its input only by handing a result over
  a_free_with_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) |-> out_tvalid)
    else $error("input freed without a result");

endmodule

bind rsa_modular_exponentiation rsa_mexp_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
